[rtl/core/ntcv_pkg.sv]
`default_nettype none
package ntcv_pkg;

    localparam int ADC_BITS_DEF     = 12;
    localparam int OVERSAMPLE_DEF   = 6;
    localparam int SERIES_TERMS_DEF = 7;

    localparam int RAW_W   = 15;
    localparam int BETA_W  = 14;
    localparam int TEMP_W  = 16;
    localparam int CFG_IDX_W = 1;

    // Q30 magnitude of t, full quotient of the front divider, series accumulator
    localparam int U_W   = 31;
    localparam int QUO_W = 32;
    localparam int ACC_W = 34;

    localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER_LAYOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA_VALUE     = 1'b1;

    localparam logic signed [TEMP_W-1:0] TEMP_MIN        = -16'sd27315;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX        = 16'sd30000;
    localparam logic signed [TEMP_W-1:0] TEMP_LOW_CLAMP  = -16'sd5000;
    localparam logic signed [TEMP_W-1:0] TEMP_HIGH_CLAMP = 16'sd10500;
    localparam logic signed [TEMP_W-1:0] TEMP_NOMINAL    = 16'sd2500;

    typedef enum logic [1:0] {
        ST_NORMAL       = 2'd0,
        ST_LOW_CLAMP    = 2'd1,
        ST_HIGH_CLAMP   = 2'd2,
        ST_OUT_OF_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        logic    res_valid;
        status_t status;
        logic    neg;
    } meta_t;

endpackage
`default_nettype wire

[rtl/core/ntcv_front.sv]
`default_nettype none
module ntcv_front #(
    parameter int ADC_BITS         = ntcv_pkg::ADC_BITS_DEF,
    parameter int OVERSAMPLE_COUNT = ntcv_pkg::OVERSAMPLE_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic                       in_v,
    input  wire logic [ntcv_pkg::RAW_W-1:0] raw_sum,
    input  wire logic                       layout,
    output logic                            v_out,
    output ntcv_pkg::meta_t                 meta_out,
    output logic [ntcv_pkg::QUO_W-1:0]      quo_out
);
    import ntcv_pkg::*;

    localparam int FS      = ((1 << ADC_BITS) - 1) * OVERSAMPLE_COUNT;
    localparam int NW      = $clog2(FS + 1);
    localparam int RW      = NW + 10;
    localparam int CMP_W   = 34;
    localparam int DSTEPS  = 4;
    localparam int DSTAGES = QUO_W / DSTEPS;
    localparam logic [CMP_W-1:0] LO_LIM = CMP_W'(FS);
    localparam logic [CMP_W-1:0] HI_LIM = CMP_W'(64'(FS) * 64'd3299);

    logic [CMP_W-1:0] s_mul;
    logic [NW-1:0]    s_n, rest, num, den, diff;
    logic             out_rng, neg;
    meta_t            meta_c;

    always_comb
    begin
        s_mul   = CMP_W'(raw_sum) * CMP_W'(3300);
        s_n     = NW'(raw_sum);
        rest    = NW'(FS) - s_n;
        num     = layout ? s_n : rest;
        den     = layout ? rest : s_n;
        out_rng = (RW'(num) * RW'(1000) <= RW'(den)) || (RW'(num) >= RW'(den) * RW'(1000));
        neg     = num < den;
        diff    = neg ? (den - num) : (num - den);
        meta_c.res_valid = 1'b1;
        meta_c.status    = ST_NORMAL;
        meta_c.neg       = neg;
        if (raw_sum == '0)
        begin
            meta_c.res_valid = 1'b0;
        end
        else if (s_mul <= LO_LIM)
        begin
            meta_c.status = ST_LOW_CLAMP;
        end
        else if (s_mul >= HI_LIM)
        begin
            meta_c.status = ST_HIGH_CLAMP;
        end
        else if (out_rng)
        begin
            meta_c.status = ST_OUT_OF_RANGE;
        end
    end

    logic              v_reg    [DSTAGES+1];
    meta_t             meta_reg [DSTAGES+1];
    logic [NW:0]       rem_reg  [DSTAGES+1];
    logic [QUO_W-1:0]  quo_reg  [DSTAGES+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta_reg[0] <= meta_c;
            rem_reg[0]  <= {1'b0, diff};
            quo_reg[0]  <= '0;
        end
    end

    // restoring division of diff * 2^32 by FS, DSTEPS quotient bits per stage
    for (genvar j = 1; j <= DSTAGES; j++)
    begin : g_div
        logic [NW:0]      r_next, r2;
        logic [QUO_W-1:0] q_next;

        always_comb
        begin
            r_next = rem_reg[j-1];
            q_next = quo_reg[j-1];
            r2     = '0;
            for (int i = 0; i < DSTEPS; i++)
            begin
                r2 = {r_next[NW-1:0], 1'b0};
                if (r2 >= (NW+1)'(FS))
                begin
                    r_next = r2 - (NW+1)'(FS);
                    q_next = {q_next[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    r_next = r2;
                    q_next = {q_next[QUO_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[j] <= v_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                meta_reg[j] <= meta_reg[j-1];
                rem_reg[j]  <= r_next;
                quo_reg[j]  <= q_next;
            end
        end
    end

    assign v_out    = v_reg[DSTAGES];
    assign meta_out = meta_reg[DSTAGES];
    assign quo_out  = quo_reg[DSTAGES];

endmodule
`default_nettype wire

[rtl/core/ntcv_series.sv]
`default_nettype none
module ntcv_series #(
    parameter int SERIES_TERMS = ntcv_pkg::SERIES_TERMS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic                       in_v,
    input  wire ntcv_pkg::meta_t            meta_in,
    input  wire logic [ntcv_pkg::QUO_W-1:0] quo_in,
    output logic                            v_out,
    output ntcv_pkg::meta_t                 meta_out,
    output logic [ntcv_pkg::ACC_W-1:0]      acc_out
);
    import ntcv_pkg::*;

    localparam int NST = 1 + 3 * (SERIES_TERMS - 1);
    localparam int PW  = 2 * U_W + 1;
    localparam logic [PW-1:0] Q30_HALF = PW'(64'd1 << 29);

    logic             v_reg    [NST];
    meta_t            meta_reg [NST];
    logic [U_W-1:0]   u2_reg   [NST];
    logic [U_W-1:0]   p_reg    [NST];
    logic [U_W-1:0]   n_reg    [NST];
    logic [U_W-1:0]   qe_reg   [NST];
    logic [ACC_W-1:0] acc_reg  [NST];

    logic [QUO_W-1:0] half_q;
    logic [U_W-1:0]   u;
    logic [PW-1:0]    sq;

    // u = round(quo / 4), the Q30 magnitude of t; then u^2 in Q30
    always_comb
    begin
        half_q = (quo_in >> 1) + QUO_W'(1);
        u      = U_W'(half_q >> 1);
        sq     = PW'(u) * PW'(u) + Q30_HALF;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta_reg[0] <= meta_in;
            u2_reg[0]   <= sq[30 +: U_W];
            p_reg[0]    <= u;
            n_reg[0]    <= '0;
            qe_reg[0]   <= '0;
            acc_reg[0]  <= ACC_W'(u);
        end
    end

    // per term: next odd power, reciprocal estimate of p / (2k+1), correct and add
    for (genvar k = 1; k < SERIES_TERMS; k++)
    begin : g_term
        localparam int SA   = 3 * k - 2;
        localparam int DV   = 2 * k + 1;
        localparam int HALF = DV / 2;
        localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(DV));

        logic [PW-1:0] pw;
        logic [U_W-1:0] n_c;
        logic [63:0]   est;
        logic [35:0]   rem_c;
        logic          inc;

        always_comb
        begin
            pw    = PW'(p_reg[SA-1]) * PW'(u2_reg[SA-1]) + Q30_HALF;
            n_c   = p_reg[SA] + U_W'(HALF);
            est   = 64'(n_c) * 64'(RECIP);
            rem_c = 36'(n_reg[SA+1]) - 36'(qe_reg[SA+1]) * 36'(DV);
            inc   = rem_c >= 36'(DV);
        end

        for (genvar m = 0; m < 3; m++)
        begin : g_vld
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[SA+m] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[SA+m] <= v_reg[SA+m-1];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                meta_reg[SA]   <= meta_reg[SA-1];
                u2_reg[SA]     <= u2_reg[SA-1];
                p_reg[SA]      <= pw[30 +: U_W];
                n_reg[SA]      <= n_reg[SA-1];
                qe_reg[SA]     <= qe_reg[SA-1];
                acc_reg[SA]    <= acc_reg[SA-1];

                meta_reg[SA+1] <= meta_reg[SA];
                u2_reg[SA+1]   <= u2_reg[SA];
                p_reg[SA+1]    <= p_reg[SA];
                n_reg[SA+1]    <= n_c;
                qe_reg[SA+1]   <= est[32 +: U_W];
                acc_reg[SA+1]  <= acc_reg[SA];

                meta_reg[SA+2] <= meta_reg[SA+1];
                u2_reg[SA+2]   <= u2_reg[SA+1];
                p_reg[SA+2]    <= p_reg[SA+1];
                n_reg[SA+2]    <= n_reg[SA+1];
                qe_reg[SA+2]   <= qe_reg[SA+1];
                acc_reg[SA+2]  <= acc_reg[SA+1] + ACC_W'(qe_reg[SA+1]) + ACC_W'(inc);
            end
        end
    end

    assign v_out    = v_reg[NST-1];
    assign meta_out = meta_reg[NST-1];
    assign acc_out  = acc_reg[NST-1];

endmodule
`default_nettype wire

[rtl/core/ntcv_beta.sv]
`default_nettype none
module ntcv_beta (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_v,
    input  wire ntcv_pkg::meta_t             meta_in,
    input  wire logic [ntcv_pkg::ACC_W-1:0]  acc_in,
    input  wire logic [ntcv_pkg::BETA_W-1:0] beta,
    output logic                             v_out,
    output logic signed [ntcv_pkg::TEMP_W-1:0] temp_out,
    output logic                             res_valid_out,
    output logic [1:0]                       status_out
);
    import ntcv_pkg::*;

    localparam int LN_W   = ACC_W - 1;
    localparam int PR_W   = LN_W + 15;
    localparam int DW     = 52;
    localparam int W      = 72;
    localparam int QB     = 18;
    localparam int DSTEPS = 2;
    localparam int DSTG   = QB / DSTEPS;
    localparam logic [QB-1:0] CK_MAX = QB'(57315);
    localparam logic [QB-1:0] K_OFS  = QB'(27315);

    typedef struct packed {
        logic beta_zero;
        logic d_zero;
        logic d_neg;
        logic sat;
    } flags_t;

    // stage 0: ln in Q27, products with the constants
    logic [ACC_W:0]  ln_t;
    logic [LN_W-1:0] ln_c;

    logic            v0_reg;
    meta_t           meta0_reg;
    logic [PR_W-1:0] prod_reg;
    logic [20:0]     bterm_reg;
    logic [35:0]     numb_reg;
    logic            bz0_reg;

    always_comb
    begin
        ln_t = (ACC_W+1)'(acc_in) + (ACC_W+1)'(2);
        ln_c = ln_t[ACC_W:2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta0_reg <= meta_in;
            prod_reg  <= PR_W'(ln_c) * PR_W'(29815);
            bterm_reg <= 21'(beta) * 21'(100);
            numb_reg  <= 36'(beta) * 36'(2981500);
            bz0_reg   <= beta == '0;
        end
    end

    // stage 1: denominator D and rounded dividend 2*num + D
    logic signed [DW-1:0] d_c;
    logic [W-1:0]         n2_c;

    always_comb
    begin
        d_c  = meta0_reg.neg ? (DW'({bterm_reg, 27'd0}) - DW'(prod_reg))
                             : (DW'({bterm_reg, 27'd0}) + DW'(prod_reg));
        n2_c = (W'(numb_reg) << 28) + W'(d_c);
    end

    logic           v1_reg;
    meta_t          meta1_reg;
    flags_t         fl1_reg;
    logic [W-1:0]   n2_reg;
    logic [W-1:0]   d2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta1_reg         <= meta0_reg;
            fl1_reg.beta_zero <= bz0_reg;
            fl1_reg.d_zero    <= d_c == '0;
            fl1_reg.d_neg     <= d_c[DW-1];
            fl1_reg.sat       <= 1'b0;
            n2_reg            <= n2_c;
            d2_reg            <= W'(d_c) << 1;
        end
    end

    // stage 2: quotient overflow check, then 2 quotient bits per stage
    logic             v_reg    [DSTG+1];
    meta_t            meta_reg [DSTG+1];
    flags_t           fl_reg   [DSTG+1];
    logic [W-1:0]     r_reg    [DSTG+1];
    logic [W-1:0]     dd_reg   [DSTG+1];
    logic [QB-1:0]    q_reg    [DSTG+1];
    flags_t           fl_c;

    always_comb
    begin
        fl_c     = fl1_reg;
        fl_c.sat = n2_reg >= (d2_reg << QB);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta_reg[0] <= meta1_reg;
            fl_reg[0]   <= fl_c;
            r_reg[0]    <= n2_reg;
            dd_reg[0]   <= d2_reg;
            q_reg[0]    <= '0;
        end
    end

    for (genvar j = 1; j <= DSTG; j++)
    begin : g_div
        logic [W-1:0]  r_next, sh;
        logic [QB-1:0] q_next;

        always_comb
        begin
            r_next = r_reg[j-1];
            q_next = q_reg[j-1];
            sh     = '0;
            for (int i = 0; i < DSTEPS; i++)
            begin
                sh = dd_reg[j-1] << (QB - 1 - DSTEPS * (j - 1) - i);
                if (r_next >= sh)
                begin
                    r_next = r_next - sh;
                    q_next[QB - 1 - DSTEPS * (j - 1) - i] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[j] <= v_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                meta_reg[j] <= meta_reg[j-1];
                fl_reg[j]   <= fl_reg[j-1];
                r_reg[j]    <= r_next;
                dd_reg[j]   <= dd_reg[j-1];
                q_reg[j]    <= q_next;
            end
        end
    end

    // output stage: pick zero, a clamp, the nominal value, a limit or the converted temperature
    meta_t                    mf;
    flags_t                   ff;
    logic signed [TEMP_W-1:0] temp_c;
    logic [QB-1:0]            qf;

    always_comb
    begin
        mf = meta_reg[DSTG];
        ff = fl_reg[DSTG];
        qf = q_reg[DSTG];
        if (!mf.res_valid)
        begin
            temp_c = '0;
        end
        else
        begin
            case (mf.status)
                ST_LOW_CLAMP:    temp_c = TEMP_LOW_CLAMP;
                ST_HIGH_CLAMP:   temp_c = TEMP_HIGH_CLAMP;
                ST_OUT_OF_RANGE: temp_c = TEMP_NOMINAL;
                default:
                begin
                    if (ff.beta_zero || (ff.d_neg && !ff.d_zero))
                    begin
                        temp_c = TEMP_MIN;
                    end
                    else if (ff.d_zero || ff.sat || qf > CK_MAX)
                    begin
                        temp_c = TEMP_MAX;
                    end
                    else
                    begin
                        temp_c = TEMP_W'(qf - K_OFS);
                    end
                end
            endcase
        end
    end

    logic                     vo_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic                     rv_reg;
    logic [1:0]               st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            vo_reg <= v_reg[DSTG];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            temp_reg <= temp_c;
            rv_reg   <= mf.res_valid;
            st_reg   <= mf.res_valid ? mf.status : ST_NORMAL;
        end
    end

    assign v_out         = vo_reg;
    assign temp_out      = temp_reg;
    assign res_valid_out = rv_reg;
    assign status_out    = st_reg;

endmodule
`default_nettype wire

[rtl/core/ntc_voltage_to_temperature_top.sv]
// Pipeline from input transfer to result: the classify/Q30 divider front end, the series
//   terms, then the beta equation (products, denominator, overflow check, 9-stage
//   quotient, output).
// Throughput: one item per cycle; the whole pipeline holds while a result is stalled.
// Reset: asynchronous, active low; clears all valid bits, divider_layout to 1, beta to 3435.
`default_nettype none
module ntc_voltage_to_temperature_top #(
    parameter int ADC_BITS         = ntcv_pkg::ADC_BITS_DEF,
    parameter int OVERSAMPLE_COUNT = ntcv_pkg::OVERSAMPLE_DEF,
    parameter int SERIES_TERMS     = ntcv_pkg::SERIES_TERMS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [ntcv_pkg::RAW_W-1:0]     raw_sum,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic signed [ntcv_pkg::TEMP_W-1:0]  temp_centi_c,
    output logic                                result_valid,
    output logic [1:0]                          range_status,
    input  wire logic                           cfg_write_en,
    input  wire logic [ntcv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ntcv_pkg::BETA_W-1:0]    cfg_data
);
    import ntcv_pkg::*;

    logic              layout_reg;
    logic [BETA_W-1:0] beta_reg;
    logic              en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layout_reg <= 1'b1;
            beta_reg   <= BETA_W'(3435);
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_DIVIDER_LAYOUT: layout_reg <= cfg_data[0];
                CFG_BETA_VALUE:     beta_reg   <= cfg_data;
                default:            ;
            endcase
        end
    end

    // pipeline moves unless the output holds a result that is not taken
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    logic             fr_v;
    meta_t            fr_meta;
    logic [QUO_W-1:0] fr_quo;

    ntcv_front #(
        .ADC_BITS         (ADC_BITS),
        .OVERSAMPLE_COUNT (OVERSAMPLE_COUNT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_v     (in_valid),
        .raw_sum  (raw_sum),
        .layout   (layout_reg),
        .v_out    (fr_v),
        .meta_out (fr_meta),
        .quo_out  (fr_quo)
    );

    logic             se_v;
    meta_t            se_meta;
    logic [ACC_W-1:0] se_acc;

    ntcv_series #(
        .SERIES_TERMS (SERIES_TERMS)
    ) u_series (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_v     (fr_v),
        .meta_in  (fr_meta),
        .quo_in   (fr_quo),
        .v_out    (se_v),
        .meta_out (se_meta),
        .acc_out  (se_acc)
    );

    ntcv_beta u_beta (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_v          (se_v),
        .meta_in       (se_meta),
        .acc_in        (se_acc),
        .beta          (beta_reg),
        .v_out         (out_valid),
        .temp_out      (temp_centi_c),
        .res_valid_out (result_valid),
        .status_out    (range_status)
    );

endmodule
`default_nettype wire

[test/tb.sv]
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ntcv_pkg::*;

    localparam longint FS        = 4095 * 6;
    localparam longint Q30       = 64'd1 << 30;
    localparam longint Q27       = 64'd1 << 27;
    localparam int     LATENCY   = 41;
    localparam longint MAX_CYCLES = 400000;

    typedef struct {
        logic signed [TEMP_W-1:0] temp;
        logic                     rvalid;
        status_t                  status;
    } reading_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [RAW_W-1:0]        raw_sum = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [TEMP_W-1:0] temp_centi_c;
    logic                    result_valid;
    logic [1:0]              range_status;
    logic                    cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = CFG_DIVIDER_LAYOUT;
    logic [BETA_W-1:0]       cfg_data = '0;

    logic [RAW_W-1:0] pending_sums[$];
    reading_t         expected_readings[$];
    logic             cur_layout;
    logic [BETA_W-1:0] cur_beta;
    int               errors = 0;
    longint           cycles = 0;
    int               gap_left = 0;
    int               stall_left = 0;
    int               hold_left = 0;

    ntc_voltage_to_temperature_top u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .raw_sum(raw_sum),
        .out_valid(out_valid), .out_stall(out_stall),
        .temp_centi_c(temp_centi_c), .result_valid(result_valid),
        .range_status(range_status),
        .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int short_or_long_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 30);
    endfunction

    function automatic longint rdiv(longint n, longint d);
        return (n + d / 2) / d;
    endfunction

    function automatic reading_t predict_reading(logic [RAW_W-1:0] s_in);
        reading_t r;
        longint s, rest, num, den, diff, u, u2, p, acc, lnq, lv, d, q, b;
        bit neg;
        s = longint'(s_in);
        r.temp = '0;
        r.rvalid = 1'b1;
        r.status = ST_NORMAL;
        if (s == 0)
        begin
            r.rvalid = 1'b0;
        end
        else if (s * 3300 <= FS)
        begin
            r.temp = TEMP_LOW_CLAMP;
            r.status = ST_LOW_CLAMP;
        end
        else if (s * 3300 >= 3299 * FS)
        begin
            r.temp = TEMP_HIGH_CLAMP;
            r.status = ST_HIGH_CLAMP;
        end
        else
        begin
            rest = FS - s;
            num = cur_layout ? s : rest;
            den = cur_layout ? rest : s;
            if (1000 * num <= den || num >= 1000 * den)
            begin
                r.temp = TEMP_NOMINAL;
                r.status = ST_OUT_OF_RANGE;
            end
            else
            begin
                neg = num < den;
                diff = neg ? den - num : num - den;
                u = (diff * Q30 + FS / 2) / FS;
                u2 = (u * u + Q30 / 2) >> 30;
                p = u;
                acc = u;
                for (int k = 1; k < 7; k++)
                begin
                    p = (p * u2 + Q30 / 2) >> 30;
                    acc += rdiv(p, 2 * k + 1);
                end
                lnq = (acc + 2) >> 2;
                lv = neg ? -lnq : lnq;
                b = longint'(cur_beta);
                if (b == 0)
                    r.temp = TEMP_MIN;
                else
                begin
                    d = b * 100 * Q27 + 29815 * lv;
                    if (d == 0)
                        r.temp = TEMP_MAX;
                    else if (d < 0)
                        r.temp = TEMP_MIN;
                    else
                    begin
                        // numerator fits 64 bits: 16383*2981500*2^27 < 2^63
                        q = rdiv(b * 2981500 * Q27, d);
                        if (q > 30000 + 27315)
                            r.temp = TEMP_MAX;
                        else
                            r.temp = TEMP_W'(q - 27315);
                    end
                end
            end
        end
        return r;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            expected_readings.push_back(predict_reading(raw_sum));
        end
        if (!in_valid || !in_stall)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_sums.size() > 0)
            begin
                raw_sum <= pending_sums.pop_front();
                in_valid <= 1'b1;
                gap_left <= short_or_long_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stall
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
            stall_left <= short_or_long_gap();
        end
    end

    // monitor
    always @(posedge clk)
    begin
        reading_t e;
        cycles <= cycles + 1;
        if (out_valid && !out_stall)
        begin
            if (expected_readings.size() == 0)
            begin
                $error("unexpected transfer: temp %0d", temp_centi_c);
                errors = errors + 1;
            end
            else
            begin
                e = expected_readings.pop_front();
                if (temp_centi_c !== e.temp)
                begin
                    $error("temp_centi_c: expected %0d actual %0d", e.temp, temp_centi_c);
                    errors = errors + 1;
                end
                if (result_valid !== e.rvalid)
                begin
                    $error("result_valid: expected %0b actual %0b", e.rvalid, result_valid);
                    errors = errors + 1;
                end
                if (range_status !== e.status)
                begin
                    $error("range_status: expected %0d actual %0d", e.status, range_status);
                    errors = errors + 1;
                end
            end
        end
        if (cycles >= MAX_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic drain();
        while (pending_sums.size() > 0 || in_valid || expected_readings.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BETA_W-1:0] val);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        if (idx == CFG_DIVIDER_LAYOUT)
            cur_layout = val[0];
        else
            cur_beta = val;
        @(posedge clk);
    endtask

    function automatic logic [RAW_W-1:0] random_sum();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return RAW_W'($urandom_range(10, 32'(FS - 10)));
        else if (r < 78)
            return RAW_W'($urandom_range(0, 30));
        else if (r < 86)
            return RAW_W'($urandom_range(32'(FS - 30), 32'(FS)));
        else if (r < 93)
            return RAW_W'($urandom_range(32'(FS + 1), 32767));
        else
            return RAW_W'($urandom_range(0, 32767));
    endfunction

    initial
    begin
        logic [BETA_W-1:0] betas[6];
        cur_layout = 1'b1;
        cur_beta = 14'd3435;
        betas = '{14'd1000, 14'd10000, 14'd3435, 14'd0, 14'd16383, 14'd1};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero, clamps edges, ratio-limit edges, midpoint, all-ones
        pending_sums = '{15'd0, 15'd1, 15'd7, 15'd8, 15'd24563, 15'd24562,
            15'd24570, 15'd24571, 15'd32767, 15'd24, 15'd25, 15'd12285,
            15'd12286, 15'd24545, 15'd24546, 15'd100, 15'd20000, 15'd16384,
            15'd8191};
        drain();

        for (int ph = 0; ph < 12; ph++)
        begin
            write_reg(CFG_DIVIDER_LAYOUT, BETA_W'(ph % 2));
            write_reg(CFG_BETA_VALUE,
                ph < 6 ? betas[ph] : BETA_W'($urandom_range(1000, 10000)));
            if (ph == 3)
                pending_sums = '{15'd12285, 15'd12286, 15'd24, 15'd24546};
            for (int i = 0; i < 52; i++)
                pending_sums.push_back(random_sum());
            if (ph == 5)
                hold_left = 200;
            drain();
        end
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire

[filelist.f]
rtl/core/ntcv_pkg.sv
rtl/core/ntcv_front.sv
rtl/core/ntcv_series.sv
rtl/core/ntcv_beta.sv
rtl/core/ntc_voltage_to_temperature_top.sv
test/tb.sv
